FILE: rtl/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define CHK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cap_pkg.sv
// Shared types and constants for the cascaded attitude PID block.
// No dependencies; used by cap_mac and cascaded_attitude_pid.
`timescale 1ns / 1ps

package cap_pkg;

  // Operand and result widths of the shared multiply-accumulate unit.
  localparam int OPA_W  = 17;
  localparam int OPB_W  = 25;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = 44;

  // Angle constants in Q11.4.
  localparam logic signed [17:0] HALF_TURN  = 18'sd2880;
  localparam logic signed [17:0] FULL_TURN  = 18'sd5760;
  localparam logic signed [16:0] DIFF_LIMIT = 17'sd480;

  // Configuration register indexes.
  localparam logic [2:0] REG_ANGLE_OUTER   = 3'd0;
  localparam logic [2:0] REG_ANGLE_INNER   = 3'd1;
  localparam logic [2:0] REG_HEADING_OUTER = 3'd2;
  localparam logic [2:0] REG_HEADING_INNER = 3'd3;
  localparam logic [2:0] REG_OUTER_LIMIT   = 3'd4;
  localparam logic [2:0] REG_INNER_LIMIT   = 3'd5;
  localparam logic [2:0] REG_YAW_LIMIT     = 3'd6;
  localparam logic [2:0] REG_INT_STEP      = 3'd7;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ACC  = 5'b00100,
    ST_POST = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  // Control bundle from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_clr;
    logic sh8;
  } mac_ctl_t;

endpackage

FILE: rtl/cap_mac.sv
// Shared signed multiply-accumulate unit: registered product, then accumulate.
// Depends on cap_pkg for widths and the control bundle.
`timescale 1ns / 1ps

module cap_mac (
  input  logic                              clk,
  input  cap_pkg::mac_ctl_t                 ctl,
  input  logic signed [cap_pkg::OPA_W-1:0]  opa,
  input  logic signed [cap_pkg::OPB_W-1:0]  opb,
  output logic signed [cap_pkg::ACC_W-1:0]  acc
);

  logic signed [cap_pkg::PROD_W-1:0] prod_r;
  logic signed [cap_pkg::ACC_W-1:0]  acc_r;
  logic signed [cap_pkg::ACC_W-1:0]  prod_ext;
  logic signed [cap_pkg::ACC_W-1:0]  addend;

  // Sign-extend the product and apply the optional Q8 alignment shift.
  assign prod_ext = {{(cap_pkg::ACC_W-cap_pkg::PROD_W){prod_r[cap_pkg::PROD_W-1]}}, prod_r};
  assign addend   = ctl.sh8 ? (prod_ext <<< 8) : prod_ext;

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= opa * opb;
    end
  end

  // Accumulate stage.
  always_ff @(posedge clk) begin
    if (ctl.acc_en) begin
      acc_r <= ctl.acc_clr ? addend : acc_r + addend;
    end
  end

  assign acc = acc_r;

endmodule

FILE: rtl/cascaded_attitude_pid.sv
// Top level of the cascaded attitude PID: registers, sequencer, state, outputs.
// Depends on cap_pkg and instantiates cap_mac.
//
// Channel  Direction  Handshake              Beat
// in_      input      in_valid / in_ready    targets, angles, gyro rates, flags
// out_     output     out_valid / out_ready  pitch, roll and yaw drive
// cfg_     input      cfg_we                 register index and write data
//
// Each beat runs six PI/PID passes on the single shared multiplier, 21 products
// in all, with an integrator step and a finish step per pass, and then one
// hand-off step before out_valid.
// in_ready is high only when idle.
// rst_n is synchronous and clears integrators, history and control state.
// A result waiting on out_ready holds the sequencer in its final step.
`timescale 1ns / 1ps

module cascaded_attitude_pid #(
  parameter int HISTORY_DEPTH = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_target_pitch,
  input  logic signed [15:0] in_target_roll,
  input  logic signed [15:0] in_target_yaw,
  input  logic signed [15:0] in_measured_pitch,
  input  logic signed [15:0] in_measured_roll,
  input  logic signed [15:0] in_measured_yaw,
  input  logic signed [15:0] in_rate_pitch,
  input  logic signed [15:0] in_rate_roll,
  input  logic signed [15:0] in_rate_yaw,
  input  logic               in_yaw_rate_mode,
  input  logic               in_clear_integrals,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_pitch_drive,
  output logic signed [15:0] out_roll_drive,
  output logic signed [15:0] out_yaw_drive,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_wdata
);

  localparam int HW = HISTORY_DEPTH - 1;

  // Configuration registers.
  logic [31:0] angle_outer_r, heading_outer_r;
  logic [47:0] angle_inner_r, heading_inner_r;
  logic [14:0] outer_lim_r, inner_lim_r, yaw_lim_r;
  logic [15:0] step_r;

  // Sequencer.
  cap_pkg::state_t state_r, state_nxt;
  logic            loop_r, loop_nxt;
  logic [1:0]      axis_r, axis_nxt;
  logic [1:0]      op_r, op_nxt;
  logic [1:0]      last_op;

  // Per-beat operands and results.
  logic signed [16:0] err_r   [3];
  logic signed [15:0] gyro_r  [3];
  logic signed [15:0] rt_r    [3];
  logic signed [15:0] drive_r [3];
  logic signed [15:0] ty_r;
  logic               mode_r;

  // Controller state.
  logic signed [23:0] oint_r [3];
  logic signed [23:0] iint_r [3];
  logic signed [15:0] hist_r [3][HW];

  // Output register.
  logic               out_valid_r;
  logic signed [15:0] out_p_r, out_r_r, out_y_r;

  // Datapath signals.
  cap_pkg::mac_ctl_t                mac_ctl;
  logic signed [cap_pkg::OPA_W-1:0] opa;
  logic signed [cap_pkg::OPB_W-1:0] opb;
  logic signed [cap_pkg::ACC_W-1:0] acc;
  logic [47:0]        gains;
  logic [15:0]        gain_f;
  logic signed [16:0] inner_err, diff_raw, diff_c;
  logic signed [16:0] yaw_err0;
  logic signed [17:0] yaw_err1;
  logic signed [23:0] cur_int;
  logic signed [26:0] int_sum, int_lim, int_new;
  logic signed [27:0] fin_raw;
  logic signed [15:0] fin_sat;
  logic signed [16:0] yaw_pre, yaw_lim, yaw_clamped;

  cap_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .opa (opa),
    .opb (opb),
    .acc (acc)
  );

  assign in_ready  = (state_r == cap_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_pitch_drive = out_p_r;
  assign out_roll_drive  = out_r_r;
  assign out_yaw_drive   = out_y_r;
  assign last_op = loop_r ? 2'd3 : 2'd2;

  // Configuration write decoder.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_outer_r   <= '0;
      angle_inner_r   <= '0;
      heading_outer_r <= '0;
      heading_inner_r <= '0;
      outer_lim_r     <= 15'd320;
      inner_lim_r     <= 15'd1600;
      yaw_lim_r       <= '0;
      step_r          <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cap_pkg::REG_ANGLE_OUTER:   angle_outer_r   <= cfg_wdata[31:0];
        cap_pkg::REG_ANGLE_INNER:   angle_inner_r   <= cfg_wdata;
        cap_pkg::REG_HEADING_OUTER: heading_outer_r <= cfg_wdata[31:0];
        cap_pkg::REG_HEADING_INNER: heading_inner_r <= cfg_wdata;
        cap_pkg::REG_OUTER_LIMIT:   outer_lim_r     <= cfg_wdata[14:0];
        cap_pkg::REG_INNER_LIMIT:   inner_lim_r     <= cfg_wdata[14:0];
        cap_pkg::REG_YAW_LIMIT:     yaw_lim_r       <= cfg_wdata[14:0];
        cap_pkg::REG_INT_STEP:      step_r          <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Yaw heading error, wrapped once into about +-180 degrees.
  always_comb begin
    yaw_err0 = 17'(in_target_yaw) - 17'(in_measured_yaw);
    yaw_err1 = 18'(yaw_err0);
    if (yaw_err1 > cap_pkg::HALF_TURN) begin
      yaw_err1 = yaw_err1 - cap_pkg::FULL_TURN;
    end else if (yaw_err1 < -cap_pkg::HALF_TURN) begin
      yaw_err1 = yaw_err1 + cap_pkg::FULL_TURN;
    end
  end

  // Inner error and clamped derivative for the current axis.
  always_comb begin
    inner_err = 17'(rt_r[axis_r]) - 17'(gyro_r[axis_r]);
    diff_raw  = 17'(hist_r[axis_r][0]) - 17'(gyro_r[axis_r]);
    if (diff_raw > cap_pkg::DIFF_LIMIT) begin
      diff_c = cap_pkg::DIFF_LIMIT;
    end else if (diff_raw < -cap_pkg::DIFF_LIMIT) begin
      diff_c = -cap_pkg::DIFF_LIMIT;
    end else begin
      diff_c = diff_raw;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    if (loop_r) begin
      gains   = (axis_r == 2'd2) ? heading_inner_r : angle_inner_r;
      cur_int = iint_r[axis_r];
    end else begin
      gains   = (axis_r == 2'd2) ? {16'd0, heading_outer_r} : {16'd0, angle_outer_r};
      cur_int = oint_r[axis_r];
    end
    case (op_r)
      2'd1:    gain_f = gains[15:0];
      2'd2:    gain_f = loop_r ? gains[47:32] : gains[31:16];
      default: gain_f = gains[31:16];
    endcase
    if (op_r == 2'd0) begin
      opa = $signed({1'b0, step_r});
    end else begin
      opa = $signed({1'b0, gain_f});
    end
    if (op_r == 2'd2 && loop_r) begin
      opb = 25'(diff_c);
    end else if (op_r == last_op) begin
      opb = 25'(cur_int);
    end else begin
      opb = loop_r ? 25'(inner_err) : 25'(err_r[axis_r]);
    end
    mac_ctl.mul_en  = (state_r == cap_pkg::ST_MUL);
    mac_ctl.acc_en  = (state_r == cap_pkg::ST_ACC);
    mac_ctl.acc_clr = (op_r <= 2'd1);
    mac_ctl.sh8     = (op_r == 2'd1) || (op_r == 2'd2 && loop_r);
  end

  // Integrator update and final saturation from the accumulator.
  always_comb begin
    int_sum = 27'(cur_int) + 27'($signed(acc[33:8]));
    int_lim = $signed({4'b0, (loop_r ? inner_lim_r : outer_lim_r), 8'b0});
    if (int_sum > int_lim) begin
      int_new = int_lim;
    end else if (int_sum < -int_lim) begin
      int_new = -int_lim;
    end else begin
      int_new = int_sum;
    end
    fin_raw = acc[43:16];
    if (fin_raw > 28'sd32767) begin
      fin_sat = 16'sh7fff;
    end else if (fin_raw < -28'sd32768) begin
      fin_sat = 16'sh8000;
    end else begin
      fin_sat = fin_raw[15:0];
    end
    yaw_pre = mode_r ? 17'(ty_r) : 17'(fin_sat);
    yaw_lim = $signed({2'b0, yaw_lim_r});
    if (yaw_pre > yaw_lim) begin
      yaw_clamped = yaw_lim;
    end else if (yaw_pre < -yaw_lim) begin
      yaw_clamped = -yaw_lim;
    end else begin
      yaw_clamped = yaw_pre;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    loop_nxt  = loop_r;
    axis_nxt  = axis_r;
    op_nxt    = op_r;
    unique case (state_r)
      cap_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = cap_pkg::ST_MUL;
          loop_nxt  = 1'b0;
          axis_nxt  = 2'd0;
          op_nxt    = 2'd0;
        end
      end
      cap_pkg::ST_MUL: state_nxt = cap_pkg::ST_ACC;
      cap_pkg::ST_ACC: begin
        if (op_r == 2'd0 || op_r == last_op) begin
          state_nxt = cap_pkg::ST_POST;
        end else begin
          op_nxt    = op_r + 2'd1;
          state_nxt = cap_pkg::ST_MUL;
        end
      end
      cap_pkg::ST_POST: begin
        state_nxt = cap_pkg::ST_MUL;
        if (op_r == 2'd0) begin
          op_nxt = 2'd1;
        end else begin
          op_nxt = 2'd0;
          if (axis_r == 2'd2) begin
            axis_nxt = 2'd0;
            if (loop_r) begin
              state_nxt = cap_pkg::ST_DONE;
            end else begin
              loop_nxt = 1'b1;
            end
          end else begin
            axis_nxt = axis_r + 2'd1;
          end
        end
      end
      cap_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = cap_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cap_pkg::ST_IDLE;
    endcase
  end

  // Sequencer and output handshake registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cap_pkg::ST_IDLE;
      loop_r      <= 1'b0;
      axis_r      <= 2'd0;
      op_r        <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      loop_r  <= loop_nxt;
      axis_r  <= axis_nxt;
      op_r    <= op_nxt;
      if (state_r == cap_pkg::ST_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (state_r == cap_pkg::ST_DONE && (!out_valid_r || out_ready)) begin
      out_p_r <= drive_r[0];
      out_r_r <= drive_r[1];
      out_y_r <= drive_r[2];
    end
  end

  // Beat capture and per-pass results.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      err_r[0]  <= 17'(in_target_pitch) - 17'(in_measured_pitch);
      err_r[1]  <= 17'(in_target_roll) - 17'(in_measured_roll);
      err_r[2]  <= yaw_err1[16:0];
      gyro_r[0] <= in_rate_pitch;
      gyro_r[1] <= in_rate_roll;
      gyro_r[2] <= in_rate_yaw;
      ty_r      <= in_target_yaw;
      mode_r    <= in_yaw_rate_mode;
    end
    if (state_r == cap_pkg::ST_POST && op_r != 2'd0) begin
      if (loop_r) begin
        drive_r[axis_r] <= fin_sat;
      end else if (axis_r == 2'd2) begin
        rt_r[axis_r] <= yaw_clamped[15:0];
      end else begin
        rt_r[axis_r] <= fin_sat;
      end
    end
  end

  // Integrators and gyro history.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        oint_r[a] <= '0;
        iint_r[a] <= '0;
        for (int i = 0; i < HW; i++) begin
          hist_r[a][i] <= '0;
        end
      end
    end else if (in_valid && in_ready) begin
      if (in_clear_integrals) begin
        for (int a = 0; a < 3; a++) begin
          oint_r[a] <= '0;
          iint_r[a] <= '0;
        end
      end
    end else if (state_r == cap_pkg::ST_POST) begin
      if (op_r == 2'd0) begin
        // Integrator step; yaw in rate mode holds its outer integrator at zero.
        if (loop_r) begin
          iint_r[axis_r] <= int_new[23:0];
        end else if (axis_r == 2'd2 && mode_r) begin
          oint_r[axis_r] <= '0;
        end else begin
          oint_r[axis_r] <= int_new[23:0];
        end
      end else if (loop_r) begin
        for (int i = 0; i < HW - 1; i++) begin
          hist_r[axis_r][i] <= hist_r[axis_r][i+1];
        end
        hist_r[axis_r][HW-1] <= gyro_r[axis_r];
      end
    end
  end

endmodule

FILE: rtl/cap_checker.sv
// Port-level checker for cascaded_attitude_pid, attached by bind.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cap_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_pitch_drive
);

  // The block is busy for the cycles right after taking a beat.
  `CHK_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready right after a beat")

  // A new result only appears at the end of a busy stretch.
  `CHK_IMPL(a_result_after_busy, $rose(out_valid), $past(!in_ready), "result without work")

  // A stalled result holds.
  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pitch_drive),
    "stalled result changed")

endmodule

bind cascaded_attitude_pid cap_checker u_cap_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_pitch_drive (out_pitch_drive)
);
